// ===== hw/rtl/fccw_pkg.sv =====
// Shared types and constants for the FAT cluster chain cache walker.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none
package fccw_pkg;

   localparam int CACHE_ENTRIES = 16;
   localparam int SLOT_W = $clog2(CACHE_ENTRIES);
   localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
   localparam int CL_W = 28;
   localparam int CSR_IDX_W = 3;

   localparam logic [15:0] FAT16_END = 16'hfff8;
   localparam logic [CL_W-1:0] FAT32_MASK = 28'hfffffff;
   localparam logic [CL_W-1:0] FAT32_END = 28'hffffff8;
   localparam logic [12:0] DEFAULT_SECTOR = 13'd512;

   // request command codes
   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_WORD = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // response kinds
   localparam logic [1:0] KIND_READ = 2'd0;
   localparam logic [1:0] KIND_FOUND = 2'd1;
   localparam logic [1:0] KIND_END = 2'd2;
   localparam logic [1:0] KIND_CLEARED = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FAT_IS_32 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTOR_SIZE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPC = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DATA = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_CUSED,
      ST_CCHK,
      ST_CMOVE,
      ST_CZERO,
      ST_CEND,
      ST_FILL,
      ST_STARTED,
      ST_DIV,
      ST_MUL,
      ST_EMIT
   } fsm_state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_SCAN,
      OP_CUSED,
      OP_CCHK,
      OP_CMOVE,
      OP_CZERO,
      OP_RESCAN,
      OP_NOBASE,
      OP_SET_CLR,
      OP_SET_END0,
      OP_START_FC,
      OP_FILL,
      OP_FIN_OK,
      OP_FIN_END,
      OP_ADVANCE,
      OP_DIV_START,
      OP_DIV_STEP,
      OP_MUL,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       busy;
      logic       fc_zero;
      logic       idx_ones;
      logic       word_end;
      logic       rem_zero;
      logic       sc_stop;
      logic       sc_hit;
      logic       ptr_last;
      logic       cused_done;
      logic       chk_move;
      logic       removed_nz;
      logic       rescan;
      logic       div_last;
      logic       out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/fccw_if.sv =====
// Request and response channel interfaces of the cluster chain walker.
// Depends on fccw_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface fccw_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  command;
   logic [fccw_pkg::CL_W-1:0]   head_cluster;
   logic [31:0]                 cluster_index;
   logic [31:0]                 fat_entry;
   modport source (output valid, command, head_cluster, cluster_index, fat_entry,
                   input ready);
   modport sink (input valid, command, head_cluster, cluster_index, fat_entry,
                 output ready);
endinterface

interface fccw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  kind;
   logic [31:0]                 fat_sector;
   logic [11:0]                 fat_offset;
   logic [fccw_pkg::CL_W-1:0]   cluster;
   logic [31:0]                 data_sector;
   logic [4:0]                  removed_count;
   modport source (output valid, kind, fat_sector, fat_offset, cluster, data_sector,
                   removed_count, input ready);
   modport sink (input valid, kind, fat_sector, fat_offset, cluster, data_sector,
                 removed_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fccw_datapath.sv =====
// Datapath: config registers, cache entries, walk state, divider, multiplier, output register.
// Driven by fccw_ctrl through dp_cmd_type; depends on fccw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fccw_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire fccw_pkg::dp_cmd_type              cmd,
   output      fccw_pkg::dp_status_type           status,
   input  wire logic [1:0]                        req_command,
   input  wire logic [fccw_pkg::CL_W-1:0]         req_head_cluster,
   input  wire logic [31:0]                       req_cluster_index,
   input  wire logic [31:0]                       req_fat_entry,
   input  wire logic                              csr_we,
   input  wire logic [fccw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [31:0]                       csr_wdata,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [1:0]                        rsp_kind,
   output      logic [31:0]                       rsp_fat_sector,
   output      logic [11:0]                       rsp_fat_offset,
   output      logic [fccw_pkg::CL_W-1:0]         rsp_cluster,
   output      logic [31:0]                       rsp_data_sector,
   output      logic [4:0]                        rsp_removed_count
);
   localparam int SW = fccw_pkg::SLOT_W;
   localparam int CW = fccw_pkg::CNT_W;
   localparam int CLW = fccw_pkg::CL_W;
   localparam logic [SW-1:0] LAST_SLOT = SW'(fccw_pkg::CACHE_ENTRIES - 1);

   // configuration
   logic        fat32_ff;
   logic [15:0] reserved_ff;
   logic [12:0] ssize_ff;
   logic [7:0]  spc_ff;
   logic [31:0] fds_ff;

   // cache
   logic [CLW-1:0] key_ff [fccw_pkg::CACHE_ENTRIES];
   logic [31:0]    cidx_ff [fccw_pkg::CACHE_ENTRIES];
   logic [31:0]    cnext_ff [fccw_pkg::CACHE_ENTRIES];

   // latched request
   logic [1:0]     cmd_ff;
   logic [CLW-1:0] fc_ff;
   logic [31:0]    idx_ff;
   logic [31:0]    raw_ff;

   // scan / clear bookkeeping
   logic [SW-1:0]  ptr_ff;
   logic [CW-1:0]  used_ff;
   logic [CW-1:0]  removed_ff;
   logic           rescan_ff;
   logic           fill_v_ff;
   logic [SW-1:0]  fill_ff;
   logic           base_v_ff;
   logic [31:0]    base_idx_ff;
   logic [CLW-1:0] base_next_ff;

   // walk
   logic [CLW-1:0] cur_ff;
   logic [CLW-1:0] wres_ff;
   logic [31:0]    wrem_ff;
   logic           slot_v_ff;
   logic [SW-1:0]  slot_ff;
   logic           busy_ff;

   // divider and multiplier
   logic [31:0]    divq_ff;
   logic [12:0]    divr_ff;
   logic [12:0]    divd_ff;
   logic [4:0]     divc_ff;
   logic [31:0]    prod_ff;

   // staged result
   logic [1:0]     res_kind_ff;
   logic [CLW-1:0] res_cl_ff;

   // output register
   logic           rsp_valid_ff;
   logic [1:0]     rsp_kind_ff;
   logic [31:0]    rsp_fsec_ff;
   logic [11:0]    rsp_foff_ff;
   logic [CLW-1:0] rsp_cl_ff;
   logic [31:0]    rsp_dsec_ff;
   logic [4:0]     rsp_rem_ff;

   logic [SW-1:0]  used_m1;
   logic [SW-1:0]  rd_addr;
   logic [CLW-1:0] rd_key;
   logic [31:0]    rd_idx;
   logic [31:0]    rd_next;
   logic           key_match;
   logic           sc_hit;
   logic           sc_stop;
   logic           base_upd;
   logic           chk_match;
   logic           chk_move;
   logic [CLW-1:0] word_val;
   logic           word_end;
   logic [13:0]    trial;
   logic           trial_ge;
   logic           out_free;
   logic [SW-1:0]  fill_slot;

   assign used_m1 = SW'(used_ff - CW'(1));
   assign rd_addr = (cmd.op == fccw_pkg::OP_CMOVE) ? used_m1 : ptr_ff;
   assign rd_key = key_ff[rd_addr];
   assign rd_idx = cidx_ff[rd_addr];
   assign rd_next = cnext_ff[rd_addr];

   assign key_match = (rd_key == fc_ff) && (fc_ff != '0);
   assign sc_stop = (rd_key == '0) || (key_match && rd_idx == idx_ff && rd_next == '0);
   assign sc_hit = key_match && rd_idx == idx_ff && rd_next != '0;
   assign base_upd = key_match && rd_idx != idx_ff && rd_next != '0 && !rd_next[31]
                     && rd_idx < idx_ff && (!base_v_ff || rd_idx > base_idx_ff);
   assign chk_match = key_match;
   assign chk_move = chk_match && ((CW'(ptr_ff) + CW'(1)) < used_ff);

   always_comb begin
      if (fat32_ff) begin
         word_val = raw_ff[CLW-1:0] & fccw_pkg::FAT32_MASK;
         word_end = (word_val == '0) || (word_val >= fccw_pkg::FAT32_END);
      end else begin
         word_val = CLW'(raw_ff[15:0]);
         word_end = (raw_ff[15:0] == '0) || (raw_ff[15:0] >= fccw_pkg::FAT16_END);
      end
   end

   assign trial = {divr_ff, divq_ff[31]};
   assign trial_ge = trial >= {1'b0, divd_ff};
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fill_slot = fill_v_ff ? fill_ff : '0;

   always_comb begin
      status.cmd = cmd_ff;
      status.busy = busy_ff;
      status.fc_zero = (fc_ff == '0);
      status.idx_ones = (idx_ff == '1);
      status.word_end = word_end;
      status.rem_zero = (wrem_ff == '0);
      status.sc_stop = sc_stop;
      status.sc_hit = sc_hit;
      status.ptr_last = (ptr_ff == LAST_SLOT);
      status.cused_done = (rd_key == '0) || (ptr_ff == LAST_SLOT);
      status.chk_move = chk_move;
      status.removed_nz = (removed_ff != '0);
      status.rescan = rescan_ff;
      status.div_last = (divc_ff == 5'd31);
      status.out_free = out_free;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fat32_ff <= 1'b0;
         reserved_ff <= 16'd1;
         ssize_ff <= fccw_pkg::DEFAULT_SECTOR;
         spc_ff <= 8'd1;
         fds_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            fccw_pkg::CSR_FAT_IS_32:   fat32_ff <= csr_wdata[0];
            fccw_pkg::CSR_RESERVED:    reserved_ff <= csr_wdata[15:0];
            fccw_pkg::CSR_SECTOR_SIZE: ssize_ff <= csr_wdata[12:0];
            fccw_pkg::CSR_SPC:         spc_ff <= csr_wdata[7:0];
            fccw_pkg::CSR_FIRST_DATA:  fds_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // cache entries, one write address per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fccw_pkg::CACHE_ENTRIES; i++) begin
            key_ff[i] <= '0;
            cidx_ff[i] <= '0;
            cnext_ff[i] <= '0;
         end
      end else begin
         case (cmd.op)
            fccw_pkg::OP_CCHK: begin
               if (chk_match && !chk_move) begin
                  key_ff[ptr_ff] <= '0;
                  cidx_ff[ptr_ff] <= '0;
                  cnext_ff[ptr_ff] <= '0;
               end
            end
            fccw_pkg::OP_CMOVE: begin
               key_ff[ptr_ff] <= rd_key;
               cidx_ff[ptr_ff] <= rd_idx;
               cnext_ff[ptr_ff] <= rd_next;
            end
            fccw_pkg::OP_CZERO: begin
               key_ff[used_m1] <= '0;
               cidx_ff[used_m1] <= '0;
               cnext_ff[used_m1] <= '0;
            end
            fccw_pkg::OP_FILL: begin
               key_ff[fill_slot] <= fc_ff;
               cidx_ff[fill_slot] <= idx_ff;
               cnext_ff[fill_slot] <= '0;
            end
            fccw_pkg::OP_FIN_OK: begin
               if (slot_v_ff) cnext_ff[slot_ff] <= {4'b0000, wres_ff};
            end
            fccw_pkg::OP_FIN_END: begin
               if (slot_v_ff) cnext_ff[slot_ff] <= {4'b1000, wres_ff};
            end
            default: ;
         endcase
      end
   end

   // control state of the datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         slot_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ptr_ff <= '0;
         used_ff <= '0;
         removed_ff <= '0;
         rescan_ff <= 1'b0;
         fill_v_ff <= 1'b0;
         base_v_ff <= 1'b0;
         divc_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (cmd.op)
            fccw_pkg::OP_LATCH: begin
               ptr_ff <= '0;
               used_ff <= '0;
               removed_ff <= '0;
               rescan_ff <= 1'b0;
               fill_v_ff <= 1'b0;
               base_v_ff <= 1'b0;
            end
            fccw_pkg::OP_SCAN: begin
               if (sc_stop) begin
                  fill_v_ff <= 1'b1;
               end else if (!sc_hit) begin
                  if (base_upd) base_v_ff <= 1'b1;
                  ptr_ff <= ptr_ff + SW'(1);
               end
            end
            fccw_pkg::OP_CUSED: begin
               if (rd_key == '0) begin
                  used_ff <= CW'(ptr_ff);
                  ptr_ff <= '0;
               end else if (ptr_ff == LAST_SLOT) begin
                  used_ff <= CW'(fccw_pkg::CACHE_ENTRIES);
                  ptr_ff <= '0;
               end else begin
                  ptr_ff <= ptr_ff + SW'(1);
               end
            end
            fccw_pkg::OP_CCHK: begin
               if (chk_match) removed_ff <= removed_ff + CW'(1);
               if (!chk_move) begin
                  if (chk_match && CW'(ptr_ff) < used_ff) used_ff <= CW'(ptr_ff);
                  ptr_ff <= ptr_ff + SW'(1);
               end
            end
            fccw_pkg::OP_CZERO: used_ff <= used_ff - CW'(1);
            fccw_pkg::OP_RESCAN: begin
               ptr_ff <= '0;
               rescan_ff <= 1'b1;
               fill_v_ff <= 1'b0;
               base_v_ff <= 1'b0;
            end
            fccw_pkg::OP_NOBASE: begin
               fill_v_ff <= 1'b0;
               base_v_ff <= 1'b0;
            end
            fccw_pkg::OP_START_FC: slot_v_ff <= 1'b0;
            fccw_pkg::OP_FILL: slot_v_ff <= 1'b1;
            fccw_pkg::OP_FIN_OK, fccw_pkg::OP_FIN_END: begin
               busy_ff <= 1'b0;
               slot_v_ff <= 1'b0;
            end
            fccw_pkg::OP_DIV_START: begin
               busy_ff <= 1'b1;
               divc_ff <= '0;
            end
            fccw_pkg::OP_DIV_STEP: divc_ff <= divc_ff + 5'd1;
            fccw_pkg::OP_EMIT: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         fccw_pkg::OP_LATCH: begin
            cmd_ff <= req_command;
            fc_ff <= req_head_cluster;
            idx_ff <= req_cluster_index;
            raw_ff <= req_fat_entry;
         end
         fccw_pkg::OP_SCAN: begin
            if (sc_stop) begin
               fill_ff <= ptr_ff;
            end else if (sc_hit) begin
               res_cl_ff <= rd_next[CLW-1:0];
               res_kind_ff <= rd_next[31] ? fccw_pkg::KIND_END : fccw_pkg::KIND_FOUND;
            end else if (base_upd) begin
               base_idx_ff <= rd_idx;
               base_next_ff <= rd_next[CLW-1:0];
            end
         end
         fccw_pkg::OP_SET_CLR: res_kind_ff <= fccw_pkg::KIND_CLEARED;
         fccw_pkg::OP_SET_END0: begin
            res_kind_ff <= fccw_pkg::KIND_END;
            res_cl_ff <= '0;
         end
         fccw_pkg::OP_START_FC: begin
            cur_ff <= fc_ff;
            wres_ff <= fc_ff;
            wrem_ff <= idx_ff;
         end
         fccw_pkg::OP_FILL: begin
            slot_ff <= fill_slot;
            if (base_v_ff) begin
               cur_ff <= base_next_ff;
               wres_ff <= base_next_ff;
               wrem_ff <= idx_ff - base_idx_ff;
            end else begin
               cur_ff <= fc_ff;
               wres_ff <= fc_ff;
               wrem_ff <= idx_ff;
            end
         end
         fccw_pkg::OP_ADVANCE: begin
            cur_ff <= word_val;
            wres_ff <= word_val;
            wrem_ff <= wrem_ff - 32'd1;
         end
         fccw_pkg::OP_FIN_OK: begin
            res_kind_ff <= fccw_pkg::KIND_FOUND;
            res_cl_ff <= wres_ff;
         end
         fccw_pkg::OP_FIN_END: begin
            res_kind_ff <= fccw_pkg::KIND_END;
            res_cl_ff <= wres_ff;
         end
         fccw_pkg::OP_DIV_START: begin
            divq_ff <= fat32_ff ? {2'b00, cur_ff, 2'b00} : {3'b000, cur_ff, 1'b0};
            divr_ff <= '0;
            divd_ff <= (ssize_ff == '0) ? fccw_pkg::DEFAULT_SECTOR : ssize_ff;
         end
         fccw_pkg::OP_DIV_STEP: begin
            // restoring division, one quotient bit a cycle
            divr_ff <= trial_ge ? 13'(trial - {1'b0, divd_ff}) : trial[12:0];
            divq_ff <= {divq_ff[30:0], trial_ge};
            if (divc_ff == 5'd31) res_kind_ff <= fccw_pkg::KIND_READ;
         end
         fccw_pkg::OP_MUL: prod_ff <= 32'(({4'b0000, res_cl_ff} - 32'd2) * spc_ff);
         fccw_pkg::OP_EMIT: begin
            rsp_kind_ff <= res_kind_ff;
            rsp_fsec_ff <= (res_kind_ff == fccw_pkg::KIND_READ)
                           ? 32'(reserved_ff) + divq_ff : '0;
            rsp_foff_ff <= (res_kind_ff == fccw_pkg::KIND_READ) ? divr_ff[11:0] : '0;
            rsp_cl_ff <= (res_kind_ff == fccw_pkg::KIND_FOUND ||
                          res_kind_ff == fccw_pkg::KIND_END) ? res_cl_ff : '0;
            rsp_dsec_ff <= (res_kind_ff == fccw_pkg::KIND_FOUND) ? prod_ff + fds_ff : '0;
            rsp_rem_ff <= (res_kind_ff == fccw_pkg::KIND_CLEARED) ? 5'(removed_ff) : '0;
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_fat_sector = rsp_fsec_ff;
   assign rsp_fat_offset = rsp_foff_ff;
   assign rsp_cluster = rsp_cl_ff;
   assign rsp_data_sector = rsp_dsec_ff;
   assign rsp_removed_count = rsp_rem_ff;

`ifndef NO_ASSERTIONS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == fccw_pkg::OP_EMIT |-> out_free)
      else $error("response loaded while previous one still held");
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(fccw_pkg::CACHE_ENTRIES))
      else $error("used count beyond cache size");
   a_move_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.op == fccw_pkg::OP_CMOVE |-> used_ff != '0)
      else $error("entry move with empty cache");
   a_fill_walk: assert property (@(posedge clock) disable iff (reset)
      cmd.op == fccw_pkg::OP_FILL |=> slot_v_ff && !busy_ff)
      else $error("walk slot not armed after fill");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/fccw_ctrl.sv =====
// Controller state machine of the cluster chain walker; issues at most one datapath op per cycle.
// Depends on fccw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fccw_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire fccw_pkg::dp_status_type status,
   output      fccw_pkg::dp_cmd_type    cmd
);
   fccw_pkg::fsm_state_type state_ff, state_in;
   logic busy_cmd;

   assign busy_cmd = status.cmd == fccw_pkg::CMD_LOOKUP || status.cmd == fccw_pkg::CMD_CLEAR;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fccw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fccw_pkg::ST_IDLE: if (req_valid) state_in = fccw_pkg::ST_DISPATCH;
         fccw_pkg::ST_DISPATCH: begin
            if (status.cmd == fccw_pkg::CMD_WORD && status.busy) begin
               state_in = status.word_end ? fccw_pkg::ST_EMIT : fccw_pkg::ST_STARTED;
            end else if (busy_cmd && status.busy) begin
               state_in = fccw_pkg::ST_DIV;
            end else if (status.cmd == fccw_pkg::CMD_CLEAR) begin
               state_in = fccw_pkg::ST_CUSED;
            end else if (status.cmd == fccw_pkg::CMD_LOOKUP) begin
               if (status.fc_zero) state_in = fccw_pkg::ST_EMIT;
               else if (status.idx_ones) state_in = fccw_pkg::ST_STARTED;
               else state_in = fccw_pkg::ST_SCAN;
            end else begin
               state_in = fccw_pkg::ST_IDLE;
            end
         end
         fccw_pkg::ST_SCAN: begin
            if (status.sc_stop) state_in = fccw_pkg::ST_FILL;
            else if (status.sc_hit) state_in = status.rescan ? fccw_pkg::ST_FILL
                                                               : fccw_pkg::ST_MUL;
            else if (status.ptr_last) state_in = status.rescan ? fccw_pkg::ST_FILL
                                                                : fccw_pkg::ST_CUSED;
         end
         fccw_pkg::ST_CUSED: if (status.cused_done) state_in = fccw_pkg::ST_CCHK;
         fccw_pkg::ST_CCHK: begin
            if (status.chk_move) state_in = fccw_pkg::ST_CMOVE;
            else if (status.ptr_last) state_in = fccw_pkg::ST_CEND;
         end
         fccw_pkg::ST_CMOVE: state_in = fccw_pkg::ST_CZERO;
         fccw_pkg::ST_CZERO: state_in = fccw_pkg::ST_CCHK;
         fccw_pkg::ST_CEND: begin
            if (status.cmd == fccw_pkg::CMD_LOOKUP)
               state_in = status.removed_nz ? fccw_pkg::ST_SCAN : fccw_pkg::ST_FILL;
            else
               state_in = fccw_pkg::ST_EMIT;
         end
         fccw_pkg::ST_FILL: state_in = fccw_pkg::ST_STARTED;
         fccw_pkg::ST_STARTED: state_in = status.rem_zero ? fccw_pkg::ST_MUL
                                                         : fccw_pkg::ST_DIV;
         fccw_pkg::ST_DIV: if (status.div_last) state_in = fccw_pkg::ST_EMIT;
         fccw_pkg::ST_MUL: state_in = fccw_pkg::ST_EMIT;
         fccw_pkg::ST_EMIT: if (status.out_free) state_in = fccw_pkg::ST_IDLE;
         default: state_in = fccw_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op = fccw_pkg::OP_NONE;
      unique case (state_ff)
         fccw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = fccw_pkg::OP_LATCH;
         end
         fccw_pkg::ST_DISPATCH: begin
            if (status.cmd == fccw_pkg::CMD_WORD && status.busy)
               cmd.op = status.word_end ? fccw_pkg::OP_FIN_END : fccw_pkg::OP_ADVANCE;
            else if (busy_cmd && status.busy)
               cmd.op = fccw_pkg::OP_DIV_START;
            else if (status.cmd == fccw_pkg::CMD_LOOKUP && status.fc_zero)
               cmd.op = fccw_pkg::OP_SET_END0;
            else if (status.cmd == fccw_pkg::CMD_LOOKUP && status.idx_ones)
               cmd.op = fccw_pkg::OP_START_FC;
         end
         fccw_pkg::ST_SCAN: cmd.op = fccw_pkg::OP_SCAN;
         fccw_pkg::ST_CUSED: cmd.op = fccw_pkg::OP_CUSED;
         fccw_pkg::ST_CCHK: cmd.op = fccw_pkg::OP_CCHK;
         fccw_pkg::ST_CMOVE: cmd.op = fccw_pkg::OP_CMOVE;
         fccw_pkg::ST_CZERO: cmd.op = fccw_pkg::OP_CZERO;
         fccw_pkg::ST_CEND: begin
            if (status.cmd == fccw_pkg::CMD_LOOKUP)
               cmd.op = status.removed_nz ? fccw_pkg::OP_RESCAN : fccw_pkg::OP_NOBASE;
            else
               cmd.op = fccw_pkg::OP_SET_CLR;
         end
         fccw_pkg::ST_FILL: cmd.op = fccw_pkg::OP_FILL;
         fccw_pkg::ST_STARTED: cmd.op = status.rem_zero ? fccw_pkg::OP_FIN_OK
                                                       : fccw_pkg::OP_DIV_START;
         fccw_pkg::ST_DIV: cmd.op = fccw_pkg::OP_DIV_STEP;
         fccw_pkg::ST_MUL: cmd.op = fccw_pkg::OP_MUL;
         fccw_pkg::ST_EMIT: if (status.out_free) cmd.op = fccw_pkg::OP_EMIT;
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// ===== hw/rtl/fat_cluster_chain_cache_walker_top.sv =====
// Top level of the FAT16/FAT32 cluster chain walker with lookup cache.
// Depends on fccw_pkg, fccw_if, fccw_ctrl and fccw_datapath.
//
//   port      dir   carries
//   req_bus   in    command, head_cluster, cluster_index, fat_entry
//   rsp_bus   out   kind, fat_sector, fat_offset, cluster, data_sector, removed_count
//   csr_*     in    register writes, index 0..4
//
// One request at a time. A cache hit steps through accept, dispatch, the scan of the
// cache entries, multiply and emit; a FAT word that leads to the next read request
// passes the bit-serial sector divider. A full cache adds a clear pass and, if
// entries were removed, a rescan.
// Reset is synchronous and empties the cache. A stalled response holds the block
// in its emit state; the next request is taken once the response register frees.
`timescale 1ns / 1ps
`default_nettype none
module fat_cluster_chain_cache_walker_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   fccw_req_if.sink                               req_bus,
   fccw_rsp_if.source                             rsp_bus,
   input  wire logic                              csr_we,
   input  wire logic [fccw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [31:0]                       csr_wdata
);
   fccw_pkg::dp_cmd_type    dp_cmd;
   fccw_pkg::dp_status_type dp_status;

   fccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   fccw_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .status            (dp_status),
      .req_command       (req_bus.command),
      .req_head_cluster  (req_bus.head_cluster),
      .req_cluster_index (req_bus.cluster_index),
      .req_fat_entry     (req_bus.fat_entry),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_kind          (rsp_bus.kind),
      .rsp_fat_sector    (rsp_bus.fat_sector),
      .rsp_fat_offset    (rsp_bus.fat_offset),
      .rsp_cluster       (rsp_bus.cluster),
      .rsp_data_sector   (rsp_bus.data_sector),
      .rsp_removed_count (rsp_bus.removed_count)
   );
endmodule
`default_nettype wire
